/* design/tlpt_pkg.sv */
// shared types and constants for the two-level page table mapper
// used by the controller, the datapath and the top level
`default_nettype none

package tlpt_pkg;

  // number of page tables that can be allocated
  localparam int TABLE_SLOTS = 64;

  // address split: 10 directory bits, 10 table bits, 12 offset bits
  localparam int ENTRIES   = 1024;
  localparam int IDX_W     = 10;
  localparam int OFS_W     = 12;
  localparam int FRAME_W   = 20;
  localparam int PTE_W     = FRAME_W + 1;
  localparam int ADDR_W    = 32;

  localparam int SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int USED_W    = $clog2(TABLE_SLOTS + 1);
  localparam int TBL_DEPTH = TABLE_SLOTS * ENTRIES;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int DIR_W     = SLOT_W + 1;

  localparam logic [ADDR_W-1:0]  FRAME_BASE_RESET = 32'h0001_0000;
  localparam logic [FRAME_W-1:0] FRAME_CNT_MAX    = 20'hF_FFFF;

  typedef enum logic [1:0] {
    OP_XLATE = 2'd0,
    OP_MAP   = 2'd1,
    OP_ALLOC = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_DIR_ABSENT = 3'd1,
    STS_MAPPED     = 3'd2,
    STS_NO_SLOT    = 3'd3,
    STS_NO_FRAME   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_XLATE,
    RES_FRAME
  } res_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_TBL,
    S_RESP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic      clr_step;
    logic      load_item;
    logic      tbl_rd;
    logic      new_table;
    logic      pte_wr;
    logic      alloc;
    logic      res_load;
    res_kind_t res_kind;
    status_t   res_status;
    logic      out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    dir_present;
    logic    pte_present;
    logic    slots_full;
    logic    frames_out;
    logic    clr_last;
  } stat_t;

endpackage

`default_nettype wire

/* design/tlpt_req_if.sv */
// request channel of the page table mapper
// depends on nothing but the ports it carries
`default_nettype none

interface tlpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] virt_addr;
  logic [31:0] phys_frame_addr;

  modport source (output valid, output opcode, output virt_addr,
                  output phys_frame_addr, input ready);
  modport sink (input valid, input opcode, input virt_addr,
                input phys_frame_addr, output ready);
endinterface

`default_nettype wire

/* design/tlpt_rsp_if.sv */
// response channel of the page table mapper
// depends on nothing but the ports it carries
`default_nettype none

interface tlpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_addr;
  logic [2:0]  status;

  modport source (output valid, output result_addr, output status, input ready);
  modport sink (input valid, input result_addr, input status, output ready);
endinterface

`default_nettype wire

/* design/two_level_page_table_mapper_top.sv */
// Two-level page table mapper, 10/10/12 address split. After reset the block
// runs a clearing pass over the table store of TABLE_SLOTS*1024 entries
// (65536 with 64 slots) and the directory before it takes its first request;
// frame_base writes are taken during that pass too. Requests are then handled
// one at a time from acceptance to a loaded response: a directory memory
// read, a table memory read with its write-back (translate or map through a
// present directory entry only), and a response register stage. A finished
// response holds in the output register until taken.
// depends on tlpt_pkg, tlpt_req_if, tlpt_rsp_if, tlpt_ctrl and tlpt_datapath
`default_nettype none

module two_level_page_table_mapper_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tlpt_pkg::ADDR_W-1:0]  cfg_wdata,
  tlpt_req_if.sink                          req,
  tlpt_rsp_if.source                        rsp
);

  tlpt_pkg::cmd_t  cmd;
  tlpt_pkg::stat_t stat;

  // sequencer
  tlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memories and registers
  tlpt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .opcode          (req.opcode),
    .virt_addr       (req.virt_addr),
    .phys_frame_addr (req.phys_frame_addr),
    .cmd             (cmd),
    .stat            (stat),
    .result_addr     (rsp.result_addr),
    .status          (rsp.status)
  );

endmodule

`default_nettype wire

/* design/tlpt_datapath.sv */
// datapath: directory and table memories, allocation counters, result registers
// depends on tlpt_pkg for widths, codes and the command and status structs
`default_nettype none

module tlpt_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [tlpt_pkg::ADDR_W-1:0]     cfg_wdata,
  input  wire logic [1:0]                      opcode,
  input  wire logic [tlpt_pkg::ADDR_W-1:0]     virt_addr,
  input  wire logic [tlpt_pkg::ADDR_W-1:0]     phys_frame_addr,
  input  wire tlpt_pkg::cmd_t                  cmd,
  output tlpt_pkg::stat_t                      stat,
  output logic [tlpt_pkg::ADDR_W-1:0]          result_addr,
  output logic [2:0]                           status
);

  // memories: directory holds present bit and slot, table holds present and frame
  logic [tlpt_pkg::DIR_W-1:0] dir_mem [tlpt_pkg::ENTRIES];
  logic [tlpt_pkg::PTE_W-1:0] tbl_mem [tlpt_pkg::TBL_DEPTH];

  logic [tlpt_pkg::ADDR_W-1:0]  frame_base;
  logic [tlpt_pkg::FRAME_W-1:0] frame_counter;
  logic [tlpt_pkg::USED_W-1:0]  slots_used;
  logic [tlpt_pkg::TBL_AW-1:0]  clr_cnt;

  tlpt_pkg::opcode_t            op;
  logic [tlpt_pkg::ADDR_W-1:0]  va;
  logic [tlpt_pkg::ADDR_W-1:0]  pa;
  logic [tlpt_pkg::DIR_W-1:0]   dir_q;
  logic [tlpt_pkg::PTE_W-1:0]   tbl_q;
  logic [tlpt_pkg::ADDR_W-1:0]  res_addr;
  tlpt_pkg::status_t            res_sts;

  logic [tlpt_pkg::IDX_W-1:0]   dir_idx;
  logic [tlpt_pkg::IDX_W-1:0]   page_idx;
  logic [tlpt_pkg::SLOT_W-1:0]  new_slot;
  logic [tlpt_pkg::TBL_AW-1:0]  walk_addr;
  logic [tlpt_pkg::TBL_AW-1:0]  tbl_waddr;
  logic [tlpt_pkg::PTE_W-1:0]   tbl_wdata;
  logic                         tbl_we;
  logic [tlpt_pkg::IDX_W-1:0]   dir_waddr;
  logic [tlpt_pkg::DIR_W-1:0]   dir_wdata;
  logic                         dir_we;
  logic [tlpt_pkg::FRAME_W:0]   next_frame;
  logic [tlpt_pkg::PTE_W-1:0]   new_pte;

  // address fields of the held transaction
  assign dir_idx   = va[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::IDX_W];
  assign page_idx  = va[tlpt_pkg::OFS_W +: tlpt_pkg::IDX_W];
  assign new_slot  = slots_used[tlpt_pkg::SLOT_W-1:0];
  assign walk_addr = tlpt_pkg::TBL_AW'({dir_q[tlpt_pkg::SLOT_W-1:0], page_idx});
  assign new_pte   = {1'b1, pa[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFS_W]};

  // next frame number from the bump counter; bit 20 set means past the top
  assign next_frame = {1'b0, frame_base[tlpt_pkg::ADDR_W-1:tlpt_pkg::OFS_W]}
                    + {1'b0, frame_counter};

  // status back to the controller
  assign stat.op          = op;
  assign stat.dir_present = dir_q[tlpt_pkg::SLOT_W];
  assign stat.pte_present = tbl_q[tlpt_pkg::FRAME_W];
  assign stat.slots_full  = (slots_used == tlpt_pkg::USED_W'(tlpt_pkg::TABLE_SLOTS));
  assign stat.frames_out  = (frame_counter == tlpt_pkg::FRAME_CNT_MAX)
                          || next_frame[tlpt_pkg::FRAME_W];
  assign stat.clr_last    = (clr_cnt == tlpt_pkg::TBL_AW'(tlpt_pkg::TBL_DEPTH - 1));

  // write port selection: clearing pass, new table, or pte fill
  always_comb begin
    tbl_we    = cmd.clr_step || cmd.new_table || cmd.pte_wr;
    tbl_waddr = walk_addr;
    tbl_wdata = new_pte;
    dir_we    = cmd.clr_step || cmd.new_table;
    dir_waddr = dir_idx;
    dir_wdata = {1'b1, new_slot};
    if (cmd.clr_step) begin
      tbl_waddr = clr_cnt;
      tbl_wdata = '0;
      dir_waddr = clr_cnt[tlpt_pkg::IDX_W-1:0];
      dir_wdata = '0;
    end else if (cmd.new_table) begin
      tbl_waddr = tlpt_pkg::TBL_AW'({new_slot, page_idx});
    end
  end

  // directory memory, read at the accepted virtual address
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (cmd.load_item) begin
      dir_q <= dir_mem[virt_addr[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::IDX_W]];
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (cmd.tbl_rd) begin
      tbl_q <= tbl_mem[walk_addr];
    end
  end

  // held transaction fields
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op <= tlpt_pkg::opcode_t'(opcode);
      va <= virt_addr;
      pa <= phys_frame_addr;
    end
  end

  // control state: base register, counters, clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base    <= tlpt_pkg::FRAME_BASE_RESET;
      frame_counter <= '0;
      slots_used    <= '0;
      clr_cnt       <= '0;
    end else begin
      if (cfg_we) begin
        frame_base <= cfg_wdata;
      end
      if (cmd.new_table || cmd.alloc) begin
        frame_counter <= frame_counter + 1'b1;
      end
      if (cmd.new_table) begin
        slots_used <= slots_used + 1'b1;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // result and output payload registers
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_sts <= cmd.res_status;
      case (cmd.res_kind)
        tlpt_pkg::RES_XLATE: res_addr <= {tbl_q[tlpt_pkg::FRAME_W-1:0],
                                          va[tlpt_pkg::OFS_W-1:0]};
        tlpt_pkg::RES_FRAME: res_addr <= {next_frame[tlpt_pkg::FRAME_W-1:0],
                                          tlpt_pkg::OFS_W'(0)};
        default:             res_addr <= '0;
      endcase
    end
    if (cmd.out_load) begin
      result_addr <= res_addr;
      status      <= res_sts;
    end
  end

endmodule

`default_nettype wire

/* design/tlpt_ctrl.sv */
// controller: sequences clearing, directory read, table read and response
// depends on tlpt_pkg for the state type and the command and status structs
`default_nettype none

module tlpt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire tlpt_pkg::stat_t stat,
  output tlpt_pkg::cmd_t       cmd
);

  tlpt_pkg::state_t state;
  tlpt_pkg::state_t state_next;
  logic             walk;
  logic             out_free;

  // a directory hit on translate or map needs the table read
  assign walk     = stat.dir_present
                  && (stat.op == tlpt_pkg::OP_XLATE || stat.op == tlpt_pkg::OP_MAP);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == tlpt_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tlpt_pkg::S_CLEAR: if (stat.clr_last) state_next = tlpt_pkg::S_IDLE;
      tlpt_pkg::S_IDLE:  if (in_valid) state_next = tlpt_pkg::S_DIR;
      tlpt_pkg::S_DIR:   state_next = walk ? tlpt_pkg::S_TBL : tlpt_pkg::S_RESP;
      tlpt_pkg::S_TBL:   state_next = tlpt_pkg::S_RESP;
      tlpt_pkg::S_RESP:  if (out_free) state_next = tlpt_pkg::S_IDLE;
      default:           state_next = tlpt_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.res_kind   = tlpt_pkg::RES_ZERO;
    cmd.res_status = tlpt_pkg::STS_OK;
    case (state)
      tlpt_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      tlpt_pkg::S_IDLE: begin
        cmd.load_item = in_valid;
      end
      tlpt_pkg::S_DIR: begin
        if (walk) begin
          cmd.tbl_rd = 1'b1;
        end else begin
          cmd.res_load = 1'b1;
          case (stat.op)
            tlpt_pkg::OP_XLATE: cmd.res_status = tlpt_pkg::STS_DIR_ABSENT;
            tlpt_pkg::OP_MAP: begin
              if (stat.slots_full) begin
                cmd.res_status = tlpt_pkg::STS_NO_SLOT;
              end else if (stat.frames_out) begin
                cmd.res_status = tlpt_pkg::STS_NO_FRAME;
              end else begin
                cmd.new_table = 1'b1;
              end
            end
            tlpt_pkg::OP_ALLOC: begin
              if (stat.frames_out) begin
                cmd.res_status = tlpt_pkg::STS_NO_FRAME;
              end else begin
                cmd.alloc    = 1'b1;
                cmd.res_kind = tlpt_pkg::RES_FRAME;
              end
            end
            default: cmd.res_status = tlpt_pkg::STS_OK;
          endcase
        end
      end
      tlpt_pkg::S_TBL: begin
        cmd.res_load = 1'b1;
        if (stat.op == tlpt_pkg::OP_XLATE) begin
          cmd.res_kind = tlpt_pkg::RES_XLATE;
        end else if (stat.pte_present) begin
          cmd.res_status = tlpt_pkg::STS_MAPPED;
        end else begin
          cmd.pte_wr = 1'b1;
        end
      end
      tlpt_pkg::S_RESP: begin
        cmd.out_load = out_free;
      end
      default: cmd.clr_step = 1'b0;
    endcase
  end

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlpt_pkg::S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a new table is only built with a free slot and a free frame
  a_new_table_room: assert property (@(posedge clk) disable iff (rst)
    cmd.new_table |-> (!stat.slots_full && !stat.frames_out))
    else $error("table allocated without a free slot or frame");

  // a frame is only handed out while frames remain
  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> !stat.frames_out)
    else $error("frame handed out past exhaustion");

  // a pte is never overwritten once present
  a_pte_once: assert property (@(posedge clk) disable iff (rst)
    cmd.pte_wr |-> !stat.pte_present)
    else $error("present pte overwritten");

  // the table read always follows a directory read
  a_tbl_after_dir: assert property (@(posedge clk) disable iff (rst)
    (state == tlpt_pkg::S_TBL) |-> ($past(state) == tlpt_pkg::S_DIR))
    else $error("table stage entered without directory stage");

endmodule

`default_nettype wire

/* tb/sv/two_level_page_table_mapper_top_tb.sv */
// self-checking testbench for the two-level page table mapper
// keeps its own page directory, table store and frame counter model and checks every response
// depends on tlpt_pkg, tlpt_req_if, tlpt_rsp_if and two_level_page_table_mapper_top
`default_nettype none

module two_level_page_table_mapper_top_tb;

  typedef struct {
    tlpt_pkg::opcode_t op;
    logic [31:0]       va;
    logic [31:0]       pa;
  } walk_req_t;

  typedef struct {
    logic [31:0]       addr;
    tlpt_pkg::status_t sts;
  } walk_rsp_t;

  // clock, reset and configuration port
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // driven copies of the channel inputs, known from time zero
  logic        drv_valid = 1'b0;
  logic [1:0]  drv_opcode = '0;
  logic [31:0] drv_va = '0;
  logic [31:0] drv_pa = '0;
  logic        rcv_ready = 1'b0;

  tlpt_req_if req_ch();
  tlpt_rsp_if rsp_ch();

  assign req_ch.valid           = drv_valid;
  assign req_ch.opcode          = drv_opcode;
  assign req_ch.virt_addr       = drv_va;
  assign req_ch.phys_frame_addr = drv_pa;
  assign rsp_ch.ready           = rcv_ready;

  two_level_page_table_mapper_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // shadow state of the mapper
  bit [31:0]                     base_shadow = tlpt_pkg::FRAME_BASE_RESET;
  bit [31:0]                     dir_shadow [tlpt_pkg::ENTRIES];
  bit [tlpt_pkg::SLOT_W-1:0]     slot_shadow [tlpt_pkg::ENTRIES];
  bit [tlpt_pkg::PTE_W-1:0]      pte_shadow [tlpt_pkg::TBL_DEPTH];
  bit [tlpt_pkg::FRAME_W-1:0]    frames_used = '0;
  int                            tables_used = 0;

  // stimulus and expectation stores
  walk_req_t req_q[$];
  walk_rsp_t expected_q[$];
  int        req_total = 0;
  int        rsp_total = 0;
  int        err_count = 0;
  int        sts_hist [5];
  int        base_writes = 0;

  // address pools used to aim requests at live mappings
  logic [9:0]  dir_pool[$];
  logic [31:0] va_pool[$];
  bit          dir_seen [tlpt_pkg::ENTRIES];

  // idle control
  bit calm = 1'b0;
  bit req_taken = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // next free frame number from the bump counter
  function automatic bit next_frame(output logic [tlpt_pkg::FRAME_W-1:0] frame);
    logic [31:0] n;
    n = {12'b0, base_shadow[31:12]} + {12'b0, frames_used};
    frame = n[tlpt_pkg::FRAME_W-1:0];
    return !(frames_used >= tlpt_pkg::FRAME_CNT_MAX || n > 32'h000F_FFFF);
  endfunction

  // apply one request to the shadow state and return the response it should produce
  function automatic walk_rsp_t walk_predict(tlpt_pkg::opcode_t op, logic [31:0] va,
                                             logic [31:0] pa);
    walk_rsp_t                   r;
    logic [9:0]                  dir;
    logic [9:0]                  page;
    int                          idx;
    logic [tlpt_pkg::FRAME_W-1:0] frame;
    r.addr = '0;
    r.sts  = tlpt_pkg::STS_OK;
    dir    = va[31:22];
    page   = va[21:12];
    case (op)
      tlpt_pkg::OP_XLATE: begin
        if (dir_shadow[dir][0]) begin
          idx    = (int'(slot_shadow[dir]) % tlpt_pkg::TABLE_SLOTS) * tlpt_pkg::ENTRIES
                 + int'(page);
          r.addr = {pte_shadow[idx][tlpt_pkg::FRAME_W-1:0], va[11:0]};
        end else begin
          r.sts = tlpt_pkg::STS_DIR_ABSENT;
        end
      end
      tlpt_pkg::OP_MAP: begin
        if (dir_shadow[dir][0]) begin
          idx = (int'(slot_shadow[dir]) % tlpt_pkg::TABLE_SLOTS) * tlpt_pkg::ENTRIES
              + int'(page);
          if (pte_shadow[idx][tlpt_pkg::FRAME_W]) r.sts = tlpt_pkg::STS_MAPPED;
          else pte_shadow[idx] = {1'b1, pa[31:12]};
        end else if (tables_used >= tlpt_pkg::TABLE_SLOTS) begin
          r.sts = tlpt_pkg::STS_NO_SLOT;
        end else if (!next_frame(frame)) begin
          r.sts = tlpt_pkg::STS_NO_FRAME;
        end else begin
          frames_used++;
          dir_shadow[dir]  = {frame, 12'h003};
          slot_shadow[dir] = tlpt_pkg::SLOT_W'(tables_used);
          idx = (tables_used % tlpt_pkg::TABLE_SLOTS) * tlpt_pkg::ENTRIES + int'(page);
          pte_shadow[idx] = {1'b1, pa[31:12]};
          tables_used++;
        end
      end
      tlpt_pkg::OP_ALLOC: begin
        if (next_frame(frame)) begin
          frames_used++;
          r.addr = {frame, 12'h000};
        end else begin
          r.sts = tlpt_pkg::STS_NO_FRAME;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // idle length: mostly none or short, a few long, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) calm <= !calm;
  end

  // request driver
  always @(negedge clk) begin
    walk_req_t item;
    if (drv_valid && !req_taken) begin
      // hold the current transaction
    end else if (gap_left > 0) begin
      drv_valid <= 1'b0;
      gap_left--;
    end else if (req_q.size() > 0) begin
      item = req_q.pop_front();
      drv_opcode <= item.op;
      drv_va     <= item.va;
      drv_pa     <= item.pa;
      drv_valid  <= 1'b1;
      gap_left   = pick_gap();
    end else begin
      drv_valid <= 1'b0;
    end
  end

  // response receiver with random stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rcv_ready <= 1'b0;
      stall_left--;
    end else begin
      rcv_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // predict on request transactions, check response transactions
  always @(posedge clk) begin
    walk_rsp_t want;
    req_taken = 1'b0;
    if (!rst && req_ch.valid && req_ch.ready) begin
      req_taken = 1'b1;
      expected_q.push_back(walk_predict(tlpt_pkg::opcode_t'(req_ch.opcode),
                                        req_ch.virt_addr, req_ch.phys_frame_addr));
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_total++;
      if (expected_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected response: addr %h status %0d",
                   rsp_ch.result_addr, rsp_ch.status);
      end else begin
        want = expected_q.pop_front();
        sts_hist[want.sts]++;
        if (rsp_ch.result_addr !== want.addr || rsp_ch.status !== want.sts) begin
          err_count++;
          if (err_count <= 10)
            $display("response %0d mismatch: addr %h status %0d, expected addr %h status %0d",
                     rsp_total, rsp_ch.result_addr, rsp_ch.status, want.addr, want.sts);
        end
      end
    end
  end

  task automatic queue_req(tlpt_pkg::opcode_t op, logic [31:0] va, logic [31:0] pa);
    walk_req_t item;
    item.op = op;
    item.va = va;
    item.pa = pa;
    req_q.push_back(item);
    req_total++;
  endtask

  // wait until every queued transaction has been answered
  task automatic drain();
    while (rsp_total != req_total) @(negedge clk);
  endtask

  task automatic write_base(logic [31:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we      = 1'b0;
    base_shadow = value;
    base_writes++;
  endtask

  // base that leaves exactly one frame before exhaustion
  function automatic logic [31:0] last_frame_base();
    logic [31:0] top;
    top = 32'h000F_FFFF - {12'b0, frames_used};
    return (top << 12) | 32'h0000_0ABC;
  endfunction

  // random traffic, biased toward directories and pages already touched
  task automatic queue_random(int count);
    int                pick;
    int                new_pct;
    tlpt_pkg::opcode_t op;
    logic [31:0]       va;
    logic [31:0]       seed_va;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) op = tlpt_pkg::OP_XLATE;
      else if (pick < 74) op = tlpt_pkg::OP_MAP;
      else if (pick < 90) op = tlpt_pkg::OP_ALLOC;
      else op = tlpt_pkg::OP_NONE;
      new_pct = (op == tlpt_pkg::OP_MAP) ? ((dir_pool.size() < 80) ? 50 : 12) : 10;
      pick = $urandom_range(0, 99);
      if (dir_pool.size() == 0 || pick < new_pct) begin
        va = $urandom;
      end else if (pick < new_pct + 45 && va_pool.size() > 0) begin
        seed_va = va_pool[$urandom_range(0, va_pool.size() - 1)];
        va = {seed_va[31:12], 12'($urandom)};
      end else begin
        va = {dir_pool[$urandom_range(0, dir_pool.size() - 1)], 22'($urandom)};
      end
      if (op == tlpt_pkg::OP_MAP) begin
        if (!dir_seen[va[31:22]]) begin
          dir_seen[va[31:22]] = 1'b1;
          dir_pool.push_back(va[31:22]);
        end
        va_pool.push_back(va);
      end
      queue_req(op, va, $urandom);
    end
  endtask

  // stimulus sequence
  initial begin
    logic [31:0] bases [4];
    bases[0] = 32'h0000_0000;
    bases[1] = 32'hFFFF_F000;
    bases[2] = $urandom_range(0, 32'hFFFF_F000);
    bases[3] = 32'h0000_0000;

    while (rst) @(posedge clk);
    @(posedge clk);

    // directed: walks through the reset frame base
    queue_req(tlpt_pkg::OP_XLATE, 32'h0000_0000, 32'h0000_0000);   // directory entry absent
    queue_req(tlpt_pkg::OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);   // unused opcode
    queue_req(tlpt_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
    queue_req(tlpt_pkg::OP_MAP,   32'h0000_0000, 32'hFFFF_FFFF);   // creates a table
    queue_req(tlpt_pkg::OP_XLATE, 32'h0000_0FFF, 32'h0000_0000);
    queue_req(tlpt_pkg::OP_MAP,   32'h0000_0000, 32'h1234_5000);   // already mapped
    queue_req(tlpt_pkg::OP_XLATE, 32'h0000_1ABC, 32'h0000_0000);   // pte never written
    queue_req(tlpt_pkg::OP_MAP,   32'h0000_1000, 32'h0000_0000);   // existing table
    queue_req(tlpt_pkg::OP_XLATE, 32'h0000_1000, 32'h0000_0000);
    queue_req(tlpt_pkg::OP_MAP,   32'hFFFF_FFFF, 32'h1234_5678);
    queue_req(tlpt_pkg::OP_XLATE, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(tlpt_pkg::OP_XLATE, 32'hFFC0_0000, 32'h0000_0000);
    queue_req(tlpt_pkg::OP_MAP,   32'h8000_0000, 32'h0000_0FFF);
    queue_req(tlpt_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    foreach (req_q[k]) begin
      if (req_q[k].op == tlpt_pkg::OP_MAP && !dir_seen[req_q[k].va[31:22]]) begin
        dir_seen[req_q[k].va[31:22]] = 1'b1;
        dir_pool.push_back(req_q[k].va[31:22]);
      end
      if (req_q[k].op == tlpt_pkg::OP_MAP) va_pool.push_back(req_q[k].va);
    end
    drain();

    // directed: one frame left, then exhaustion
    write_base(last_frame_base());
    @(posedge clk);
    queue_req(tlpt_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
    queue_req(tlpt_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000);   // frames exhausted
    queue_req(tlpt_pkg::OP_MAP,   32'h4000_0000, 32'hABCD_E000);   // new table, no frame
    queue_req(tlpt_pkg::OP_MAP,   32'h0000_2000, 32'h0000_3000);   // existing table
    queue_req(tlpt_pkg::OP_XLATE, 32'h4000_0123, 32'h0000_0000);
    queue_req(tlpt_pkg::OP_NONE,  32'h0000_0000, 32'h0000_0000);
    drain();

    // random phases across frame base settings
    foreach (bases[p]) begin
      write_base(bases[p]);
      @(posedge clk);
      queue_random(250);
      drain();
    end

    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      err_count++;
      $display("%0d responses never arrived", expected_q.size());
    end
    $display("ran %0d requests over %0d frame base writes, %0d tables built",
             req_total, base_writes, tables_used);
    $display("status counts: ok %0d, absent %0d, mapped %0d, no slot %0d, no frame %0d",
             sts_hist[0], sts_hist[1], sts_hist[2], sts_hist[3], sts_hist[4]);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
